/* hw/rtl/dwl_pkg.sv */
// Shared types and codes for the deduplicating waypoint list.
// Used by dwl_cell and dedup_waypoint_list_top; depends on nothing.

package dwl_pkg;

  localparam int COORD_W      = 10;
  localparam int IDX_W        = 4;
  localparam int ACT_W        = 2;
  localparam int STAT_W       = 3;
  localparam int LCNT_W       = 5;
  localparam int MAX_ENTRIES  = 16;
  localparam logic [COORD_W-1:0] COORD_LIMIT = COORD_W'(999);

  // Action codes; code 3 is unused and leaves the list alone.
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISSING = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_IDX = 3'd5;

  // Command held steady by the top level while a token walks the row.
  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
  } cmd_t;

  // Token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic               vld;
    logic               found;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
  } tok_t;

endpackage

/* hw/rtl/dwl_cell.sv */
// One list slot: holds a point, compares it against the passing token,
// takes its right neighbour's point on a remove. Depends on dwl_pkg.

module dwl_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dwl_pkg::cmd_t               cmd_i,
  input  logic [CNT_W-1:0]            count_i,
  input  dwl_pkg::tok_t               tok_i,
  output dwl_pkg::tok_t               tok_o,
  input  logic [dwl_pkg::COORD_W-1:0] right_x_i,
  input  logic [dwl_pkg::COORD_W-1:0] right_y_i,
  input  logic                        pull_i,
  output logic                        pull_o,
  output logic [dwl_pkg::COORD_W-1:0] x_o,
  output logic [dwl_pkg::COORD_W-1:0] y_o
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
  localparam bit READABLE = (IDX < (1 << dwl_pkg::IDX_W));

  logic [dwl_pkg::COORD_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic                        tok_vld_r;
  logic                        found_r;
  logic [dwl_pkg::COORD_W-1:0] rx_r, ry_r;
  logic                        live;
  logic                        hit;
  logic                        rd_hit;
  logic                        wr_en;

  assign live   = IDX_C < count_i;
  assign hit    = tok_i.vld && live && (x_r == cmd_i.px) && (y_r == cmd_i.py);
  assign rd_hit = READABLE && tok_i.vld && live && (cmd_i.act == dwl_pkg::ACT_READ)
                  && (cmd_i.idx == dwl_pkg::IDX_W'(IDX));
  // Append lands in the first free slot; any duplicate sits to the left.
  assign wr_en  = tok_i.vld && (cmd_i.act == dwl_pkg::ACT_ADD) && cmd_i.in_range
                  && !tok_i.found && (IDX_C == count_i);

  // Ask the left neighbour to take this slot once the match lies behind us.
  assign pull_o = tok_i.vld && tok_i.found && (cmd_i.act == dwl_pkg::ACT_REMOVE);

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (pull_i) begin
      x_nxt = right_x_i;
      y_nxt = right_y_i;
    end else if (wr_en) begin
      x_nxt = cmd_i.px;
      y_nxt = cmd_i.py;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    found_r <= tok_i.found || hit;
    rx_r    <= rd_hit ? x_r : tok_i.rx;
    ry_r    <= rd_hit ? y_r : tok_i.ry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_i.vld;
    end
  end

  assign tok_o.vld   = tok_vld_r;
  assign tok_o.found = found_r;
  assign tok_o.rx    = rx_r;
  assign tok_o.ry    = ry_r;
  assign x_o         = x_r;
  assign y_o         = y_r;

endmodule

/* hw/rtl/dedup_waypoint_list_top.sv */
// Top level of the deduplicating waypoint list: command register, cell row
// and result register. Depends on dwl_pkg and dwl_cell.

// Each accepted beat launches a token that walks the row of MAX_ENTRIES
// cells, one cell per cycle; every cell checks its point for a match, serves
// a read, takes an appended point or shifts down on a remove as the token
// passes. One command is handled at a time: a new one is taken only once
// its token has left the row and its result has moved from the result
// register into the output register. The next command is accepted while
// the previous result still waits on out_ready. Slot contents need no
// clearing after reset; only the count and the control flags are reset.

module dedup_waypoint_list_top #(
  parameter int MAX_ENTRIES = dwl_pkg::MAX_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dwl_pkg::ACT_W-1:0]   in_action,
  input  logic [dwl_pkg::COORD_W-1:0] in_point_x,
  input  logic [dwl_pkg::COORD_W-1:0] in_point_y,
  input  logic [dwl_pkg::IDX_W-1:0]   in_entry_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dwl_pkg::STAT_W-1:0]  out_status,
  output logic [dwl_pkg::LCNT_W-1:0]  out_list_count,
  output logic [dwl_pkg::COORD_W-1:0] out_read_x,
  output logic [dwl_pkg::COORD_W-1:0] out_read_y
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > dwl_pkg::IDX_W) ? CNT_W : dwl_pkg::IDX_W;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_t;

  state_t                      state_r, state_nxt;
  dwl_pkg::cmd_t               cmd_r, cmd_nxt;
  logic                        start_r, start_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [dwl_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [dwl_pkg::COORD_W-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [dwl_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [dwl_pkg::LCNT_W-1:0]  out_count_r, out_count_nxt;
  logic [dwl_pkg::COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  dwl_pkg::tok_t               tok [MAX_ENTRIES+1];
  logic [dwl_pkg::COORD_W-1:0] cx  [MAX_ENTRIES+1];
  logic [dwl_pkg::COORD_W-1:0] cy  [MAX_ENTRIES+1];
  logic                        pull [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0]      tok_vld_vec;

  dwl_pkg::tok_t               tail;
  logic                        accept;
  logic                        full;
  logic                        idx_ok;

  assign tok[0].vld   = start_r;
  assign tok[0].found = 1'b0;
  assign tok[0].rx    = '0;
  assign tok[0].ry    = '0;
  assign cx[MAX_ENTRIES]   = '0;
  assign cy[MAX_ENTRIES]   = '0;
  assign pull[MAX_ENTRIES] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    dwl_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd_i     (cmd_r),
      .count_i   (count_r),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1]),
      .right_x_i (cx[i+1]),
      .right_y_i (cy[i+1]),
      .pull_i    (pull[i+1]),
      .pull_o    (pull[i]),
      .x_o       (cx[i]),
      .y_o       (cy[i])
    );
    assign tok_vld_vec[i] = tok[i+1].vld;
  end

  assign tail     = tok[MAX_ENTRIES];
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(MAX_ENTRIES));
  assign idx_ok   = CMP_W'(cmd_r.idx) < CMP_W'(count_r);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    start_nxt      = 1'b0;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt.act      = in_action;
          cmd_nxt.px       = in_point_x;
          cmd_nxt.py       = in_point_y;
          cmd_nxt.idx      = in_entry_index;
          cmd_nxt.in_range = (in_point_x <= dwl_pkg::COORD_LIMIT)
                             && (in_point_y <= dwl_pkg::COORD_LIMIT);
          start_nxt        = 1'b1;
          state_nxt        = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tail.vld) begin
          res_status_nxt = dwl_pkg::ST_OK;
          res_x_nxt      = '0;
          res_y_nxt      = '0;
          case (cmd_r.act)
            dwl_pkg::ACT_ADD: begin
              if (!cmd_r.in_range) begin
                res_status_nxt = dwl_pkg::ST_RANGE;
              end else if (tail.found) begin
                res_status_nxt = dwl_pkg::ST_DUP;
              end else if (full) begin
                res_status_nxt = dwl_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            dwl_pkg::ACT_REMOVE: begin
              if (tail.found) begin
                count_nxt = count_r - CNT_W'(1);
              end else begin
                res_status_nxt = dwl_pkg::ST_MISSING;
              end
            end
            dwl_pkg::ACT_READ: begin
              if (idx_ok) begin
                res_x_nxt = tail.rx;
                res_y_nxt = tail.ry;
              end else begin
                res_status_nxt = dwl_pkg::ST_BAD_IDX;
              end
            end
            default: begin
              res_status_nxt = dwl_pkg::ST_OK;
            end
          endcase
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_count_nxt  = dwl_pkg::LCNT_W'(count_r);
          out_x_nxt      = res_x_r;
          out_y_nxt      = res_y_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    res_status_r <= res_status_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_list_count = out_count_r;
  assign out_read_x     = out_x_r;
  assign out_read_y     = out_y_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("list count above capacity");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_vld_vec, start_r}))
    else $error("more than one token in the cell row");

  a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> state_r == ST_RUN)
    else $error("token left the row outside a run");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> $past(state_r) == ST_RUN && $past(tail.vld))
    else $error("count changed without a finished token");

  a_out_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_WAIT)
    else $error("result raised outside the wait state");

endmodule

/* tb/tb_dedup_waypoint_list_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for dedup_waypoint_list_top: directed and random list traffic
// against a behavioural list predictor. Depends on dwl_pkg and the top level RTL.

module tb_dedup_waypoint_list_top;

  localparam logic [dwl_pkg::ACT_W-1:0] ACT_UNUSED  = 2'd3;
  localparam int                        CYCLE_LIMIT = 1000000;
  localparam int                        DRAIN_WAIT  = dwl_pkg::MAX_ENTRIES + 6;
  localparam int                        PRINT_LIMIT = 100;

  typedef struct packed {
    logic [dwl_pkg::STAT_W-1:0]  status;
    logic [dwl_pkg::LCNT_W-1:0]  count;
    logic [dwl_pkg::COORD_W-1:0] rx;
    logic [dwl_pkg::COORD_W-1:0] ry;
  } list_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [dwl_pkg::ACT_W-1:0]   in_action;
  logic [dwl_pkg::COORD_W-1:0] in_point_x;
  logic [dwl_pkg::COORD_W-1:0] in_point_y;
  logic [dwl_pkg::IDX_W-1:0]   in_entry_index;
  logic                        out_valid;
  logic                        out_ready;
  logic [dwl_pkg::STAT_W-1:0]  out_status;
  logic [dwl_pkg::LCNT_W-1:0]  out_list_count;
  logic [dwl_pkg::COORD_W-1:0] out_read_x;
  logic [dwl_pkg::COORD_W-1:0] out_read_y;

  // Predicted list contents
  logic [dwl_pkg::COORD_W-1:0] waypoint_x [dwl_pkg::MAX_ENTRIES];
  logic [dwl_pkg::COORD_W-1:0] waypoint_y [dwl_pkg::MAX_ENTRIES];
  int                          waypoint_count;

  list_result_t pending_results [$];
  int           mismatch_count;
  int           result_count;
  int           cycle_count;
  int           burst_left;

  dedup_waypoint_list_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_list_count (out_list_count),
    .out_read_x     (out_read_x),
    .out_read_y     (out_read_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function automatic int find_waypoint(input logic [dwl_pkg::COORD_W-1:0] x,
                                       input logic [dwl_pkg::COORD_W-1:0] y);
    for (int i = 0; i < waypoint_count; i++) begin
      if (waypoint_x[i] == x && waypoint_y[i] == y) return i;
    end
    return -1;
  endfunction

  function automatic list_result_t apply_list_op(input logic [dwl_pkg::ACT_W-1:0]   act,
                                                 input logic [dwl_pkg::COORD_W-1:0] x,
                                                 input logic [dwl_pkg::COORD_W-1:0] y,
                                                 input logic [dwl_pkg::IDX_W-1:0]   idx);
    list_result_t res;
    int           pos;
    res = '0;
    res.status = dwl_pkg::ST_OK;
    case (act)
      dwl_pkg::ACT_ADD: begin
        if (x > dwl_pkg::COORD_LIMIT || y > dwl_pkg::COORD_LIMIT) begin
          res.status = dwl_pkg::ST_RANGE;
        end else if (find_waypoint(x, y) >= 0) begin
          res.status = dwl_pkg::ST_DUP;
        end else if (waypoint_count >= dwl_pkg::MAX_ENTRIES) begin
          res.status = dwl_pkg::ST_FULL;
        end else begin
          waypoint_x[waypoint_count] = x;
          waypoint_y[waypoint_count] = y;
          waypoint_count++;
        end
      end
      dwl_pkg::ACT_REMOVE: begin
        pos = find_waypoint(x, y);
        if (pos < 0) begin
          res.status = dwl_pkg::ST_MISSING;
        end else begin
          // close the gap left by the removed point
          for (int j = pos; j < waypoint_count - 1; j++) begin
            waypoint_x[j] = waypoint_x[j+1];
            waypoint_y[j] = waypoint_y[j+1];
          end
          waypoint_count--;
        end
      end
      dwl_pkg::ACT_READ: begin
        if (int'(idx) >= waypoint_count) begin
          res.status = dwl_pkg::ST_BAD_IDX;
        end else begin
          res.rx = waypoint_x[idx];
          res.ry = waypoint_y[idx];
        end
      end
      default: ;
    endcase
    res.count = dwl_pkg::LCNT_W'(waypoint_count);
    return res;
  endfunction

  // Send one beat, idling between bursts, and log its expected result on acceptance.
  task automatic send_cmd(input logic [dwl_pkg::ACT_W-1:0]   act,
                          input logic [dwl_pkg::COORD_W-1:0] x,
                          input logic [dwl_pkg::COORD_W-1:0] y,
                          input logic [dwl_pkg::IDX_W-1:0]   idx);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_action      <= act;
    in_point_x     <= x;
    in_point_y     <= y;
    in_entry_index <= idx;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_list_op(act, x, y, idx));
    burst_left--;
  endtask

  task automatic test_add_limits();
    send_cmd(dwl_pkg::ACT_READ, 10'd0, 10'd0, 4'd0);        // read on an empty list
    send_cmd(dwl_pkg::ACT_ADD, 10'd0, 10'd0, 4'd15);
    send_cmd(dwl_pkg::ACT_ADD, 10'd999, 10'd999, 4'd0);
    send_cmd(dwl_pkg::ACT_ADD, 10'd1000, 10'd5, 4'd0);
    send_cmd(dwl_pkg::ACT_ADD, 10'd5, 10'd1023, 4'd0);
    send_cmd(dwl_pkg::ACT_ADD, 10'd0, 10'd0, 4'd0);         // duplicate
    send_cmd(dwl_pkg::ACT_READ, 10'd1023, 10'd1023, 4'd2);  // index at count
  endtask

  task automatic test_fill_and_full();
    for (int k = 0; k < dwl_pkg::MAX_ENTRIES - 2; k++) begin
      send_cmd(dwl_pkg::ACT_ADD, dwl_pkg::COORD_W'(10 + k * 67),
               dwl_pkg::COORD_W'(990 - k * 61), 4'd0);
    end
    send_cmd(dwl_pkg::ACT_ADD, 10'd500, 10'd501, 4'd0);     // full
    send_cmd(dwl_pkg::ACT_ADD, 10'd999, 10'd999, 4'd0);     // duplicate wins over full
    send_cmd(dwl_pkg::ACT_ADD, 10'd1023, 10'd0, 4'd0);      // range wins over full
    send_cmd(dwl_pkg::ACT_READ, 10'd0, 10'd0, 4'd15);
  endtask

  task automatic test_remove_shift();
    send_cmd(dwl_pkg::ACT_REMOVE, 10'd999, 10'd999, 4'd0);  // second entry, shifts the rest
    send_cmd(dwl_pkg::ACT_REMOVE, 10'd1023, 10'd1023, 4'd0);
    send_cmd(dwl_pkg::ACT_READ, 10'd0, 10'd0, 4'd1);
    send_cmd(ACT_UNUSED, 10'd1023, 10'd1023, 4'd15);
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [dwl_pkg::COORD_W-1:0] pool_x [12];
    logic [dwl_pkg::COORD_W-1:0] pool_y [12];
    logic [dwl_pkg::ACT_W-1:0]   act;
    logic [dwl_pkg::COORD_W-1:0] x;
    logic [dwl_pkg::COORD_W-1:0] y;
    logic [dwl_pkg::IDX_W-1:0]   idx;
    int                          add_pct;
    int                          r;
    int                          s;
    int                          k;
    for (int p = 0; p < 12; p++) begin
      pool_x[p] = (p == 0) ? 10'd999 : dwl_pkg::COORD_W'($urandom_range(0, 999));
      pool_y[p] = (p == 1) ? 10'd999 : dwl_pkg::COORD_W'($urandom_range(0, 999));
    end
    add_pct = 60;
    for (int i = 0; i < n_items; i++) begin
      // swing between filling and draining phases
      if (i % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: add_pct = 85;
          1: add_pct = 50;
          default: add_pct = 20;
        endcase
      end
      x   = dwl_pkg::COORD_W'($urandom_range(0, 1023));
      y   = dwl_pkg::COORD_W'($urandom_range(0, 1023));
      idx = dwl_pkg::IDX_W'($urandom_range(0, 15));
      r   = $urandom_range(0, 99);
      s   = $urandom_range(0, 19);
      k   = $urandom_range(0, 11);
      if (r < 2) begin
        act = ACT_UNUSED;
      end else if (r < 14) begin
        act = dwl_pkg::ACT_READ;
        if (waypoint_count > 0 && s < 15) begin
          idx = dwl_pkg::IDX_W'($urandom_range(0, waypoint_count - 1));
        end
      end else if ($urandom_range(0, 99) < add_pct) begin
        act = dwl_pkg::ACT_ADD;
        if (s == 0) begin
          if ($urandom_range(0, 1)) x = dwl_pkg::COORD_W'($urandom_range(1000, 1023));
          else y = dwl_pkg::COORD_W'($urandom_range(1000, 1023));
        end else if (s < 3 && waypoint_count > 0) begin
          k = $urandom_range(0, waypoint_count - 1);
          x = waypoint_x[k];
          y = waypoint_y[k];
        end else if (s < 13) begin
          x = pool_x[k];
          y = pool_y[k];
        end else begin
          x = dwl_pkg::COORD_W'($urandom_range(0, 999));
          y = dwl_pkg::COORD_W'($urandom_range(0, 999));
        end
      end else begin
        act = dwl_pkg::ACT_REMOVE;
        if (s < 15 && waypoint_count > 0) begin
          k = $urandom_range(0, waypoint_count - 1);
          x = waypoint_x[k];
          y = waypoint_y[k];
        end else if (s < 18) begin
          x = pool_x[k];
          y = pool_y[k];
        end
      end
      send_cmd(act, x, y, idx);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver: stall on one of four patterns, each kept for a random stretch.
  int rx_mode;
  int rx_mode_left;
  int rx_run;
  logic rx_hold;
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      2: begin
        if (rx_run == 0) begin
          rx_hold = ~rx_hold;
          rx_run  = $urandom_range(1, 30);
        end
        rx_run--;
        out_ready <= rx_hold;
      end
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d count %0d",
                                  out_status, out_list_count));
      end else begin
        list_result_t want;
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    result_count, out_status, want.status));
        if (out_list_count !== want.count)
          report_mismatch($sformatf("result %0d list_count %0d, expected %0d",
                                    result_count, out_list_count, want.count));
        if (out_read_x !== want.rx)
          report_mismatch($sformatf("result %0d read_x %0d, expected %0d",
                                    result_count, out_read_x, want.rx));
        if (out_read_y !== want.ry)
          report_mismatch($sformatf("result %0d read_y %0d, expected %0d",
                                    result_count, out_read_y, want.ry));
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = dwl_pkg::ACT_ADD;
    in_point_x     = '0;
    in_point_y     = '0;
    in_entry_index = '0;
    out_ready      = 1'b0;
    waypoint_count = 0;
    mismatch_count = 0;
    result_count   = 0;
    cycle_count    = 0;
    burst_left     = 0;
    rx_mode        = 0;
    rx_mode_left   = 0;
    rx_run         = 0;
    rx_hold        = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_add_limits();
    test_fill_and_full();
    test_remove_shift();
    test_random_traffic(1500);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    while (pending_results.size() > 0) begin
      void'(pending_results.pop_front());
      report_mismatch("expected result never arrived");
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
